[src/bri_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bri_pkg
// shared constants and pipeline types for the bounded random integer block
// ----------------------------------------------------------------------------
package bri_pkg;

    localparam int unsigned WORD_W   = 64;
    localparam int unsigned HALF_W   = 32;
    localparam int unsigned PADDR_W  = 4;
    localparam int unsigned CNT_W    = 6;

    // register index, taken from paddr[3] (8-byte register stride)
    localparam logic REG_RANGE_SIZE = 1'b0;

    localparam logic [WORD_W-1:0] TWO_POW_32 = 64'h0000_0001_0000_0000;
    localparam logic [WORD_W-1:0] ONE_WORD   = 64'h0000_0000_0000_0001;
    localparam logic [CNT_W-1:0]  DIV_LAST   = 6'd63;

    // partial products of the 64x64 multiply
    typedef struct packed {
        logic [WORD_W-1:0] ll;
        logic [WORD_W-1:0] lh;
        logic [WORD_W-1:0] hl;
        logic [WORD_W-1:0] hh;
    } pp_t;

    // low half plus the carries still owed to the high half
    typedef struct packed {
        logic [WORD_W-1:0] lo;
        logic [1:0]        mid_carry;
        logic [HALF_W-1:0] lh_hi;
        logic [HALF_W-1:0] hl_hi;
        logic [WORD_W-1:0] hh;
    } sum_t;

endpackage

[src/bounded_random_integer.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounded_random_integer
// unbiased integers in [0, range_size) from raw random words, multiply-and-
// reject; threshold (2^k - range) mod range worked out by a serial remainder
// ----------------------------------------------------------------------------
// a kept word passes the input, product, low-half and result registers in turn
// throughput: one word per cycle unless the output stalls or the remainder
// unit is busy; a rejected word simply leaves no result; after a range_size
// write it runs one bit per cycle with in_ready low; range 0 or 1 needs none
// reset: range_size 1, narrow mode, threshold 0, pipeline empty
// ----------------------------------------------------------------------------
module bounded_random_integer
    import bri_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,

    // apb-style configuration port
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [PADDR_W-1:0]  paddr,
    input  logic [WORD_W-1:0]   pwdata,
    output logic [WORD_W-1:0]   prdata,
    output logic                pready,

    // random word in
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [WORD_W-1:0]   rand_word,

    // bounded value out
    output logic                out_valid,
    input  logic                out_ready,
    output logic [WORD_W-1:0]   value
);

    // ------------------------------------------------------------------
    // configuration state
    // ------------------------------------------------------------------
    logic [WORD_W-1:0]  range_reg;
    logic               narrow_reg;     // range_size <= 2^32
    logic               trivial_reg;    // range_size 0 or 1
    logic [WORD_W-1:0]  thr_reg;        // doubles as the running remainder
    logic [WORD_W-1:0]  dvd_reg;        // dividend, shifted out msb first
    logic [CNT_W-1:0]   cnt_reg;
    logic               busy_reg;

    logic               cfg_wr;
    logic [WORD_W:0]    rem_shift;
    logic [WORD_W:0]    rem_sub;
    logic [WORD_W-1:0]  rem_next;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr[3] == REG_RANGE_SIZE);

    always_comb
    begin
        if (paddr[3] == REG_RANGE_SIZE)
        begin
            prdata = range_reg;
        end
        else
        begin
            prdata = '0;
        end
    end

    // one restoring step: bring in the next dividend bit, subtract if it fits
    always_comb
    begin
        rem_shift = {thr_reg, dvd_reg[WORD_W-1]};
        rem_sub   = rem_shift - {1'b0, range_reg};
        if (rem_shift >= {1'b0, range_reg})
        begin
            rem_next = rem_sub[WORD_W-1:0];
        end
        else
        begin
            rem_next = rem_shift[WORD_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            range_reg   <= ONE_WORD;
            narrow_reg  <= 1'b1;
            trivial_reg <= 1'b1;
            thr_reg     <= '0;
            dvd_reg     <= '0;
            cnt_reg     <= '0;
            busy_reg    <= 1'b0;
        end
        else if (cfg_wr)
        begin
            range_reg   <= pwdata;
            narrow_reg  <= (pwdata <= TWO_POW_32);
            trivial_reg <= (pwdata <= ONE_WORD);
            thr_reg     <= '0;
            cnt_reg     <= '0;
            busy_reg    <= (pwdata > ONE_WORD);
            // dividend is 2^32 - range in narrow mode, 2^64 - range otherwise
            if (pwdata <= TWO_POW_32)
            begin
                dvd_reg <= TWO_POW_32 - pwdata;
            end
            else
            begin
                dvd_reg <= '0 - pwdata;
            end
        end
        else if (busy_reg)
        begin
            thr_reg <= rem_next;
            dvd_reg <= {dvd_reg[WORD_W-2:0], 1'b0};
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == DIV_LAST)
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // word pipeline: input reg -> partial products -> low half -> result
    // the whole pipe stalls together while a result waits on out_ready
    // ------------------------------------------------------------------
    logic               adv;
    logic               s0_valid_reg;
    logic [WORD_W-1:0]  s0_word_reg;
    logic               s1_valid_reg;
    pp_t                s1_pp_reg;
    pp_t                s1_pp_next;
    logic               s2_valid_reg;
    sum_t               s2_sum_reg;
    sum_t               s2_sum_next;
    logic               out_valid_reg;
    logic [WORD_W-1:0]  value_reg;
    logic [WORD_W-1:0]  value_next;
    logic               keep;

    logic [HALF_W-1:0]  a_lo;
    logic [HALF_W-1:0]  a_hi;
    logic [HALF_W+1:0]  mid;
    logic [WORD_W-1:0]  hi_sum;

    assign adv      = !out_valid_reg || out_ready;
    assign in_ready = adv && !busy_reg;

    // stage 1: four 32x32 partial products; narrow mode uses the low word only
    always_comb
    begin
        a_lo = s0_word_reg[HALF_W-1:0];
        a_hi = narrow_reg ? '0 : s0_word_reg[WORD_W-1:HALF_W];
        s1_pp_next.ll = a_lo * range_reg[HALF_W-1:0];
        s1_pp_next.lh = a_lo * range_reg[WORD_W-1:HALF_W];
        s1_pp_next.hl = a_hi * range_reg[HALF_W-1:0];
        s1_pp_next.hh = a_hi * range_reg[WORD_W-1:HALF_W];
    end

    // stage 2: middle column sum gives the low 64 bits of the product
    always_comb
    begin
        mid = {2'b00, s1_pp_reg.ll[WORD_W-1:HALF_W]}
            + {2'b00, s1_pp_reg.lh[HALF_W-1:0]}
            + {2'b00, s1_pp_reg.hl[HALF_W-1:0]};
        s2_sum_next.lo        = {mid[HALF_W-1:0], s1_pp_reg.ll[HALF_W-1:0]};
        s2_sum_next.mid_carry = mid[HALF_W+1:HALF_W];
        s2_sum_next.lh_hi     = s1_pp_reg.lh[WORD_W-1:HALF_W];
        s2_sum_next.hl_hi     = s1_pp_reg.hl[WORD_W-1:HALF_W];
        s2_sum_next.hh        = s1_pp_reg.hh;
    end

    // stage 3: high half and the reject compare, side by side
    always_comb
    begin
        hi_sum = s2_sum_reg.hh
               + {{HALF_W{1'b0}}, s2_sum_reg.lh_hi}
               + {{HALF_W{1'b0}}, s2_sum_reg.hl_hi}
               + {{(WORD_W-2){1'b0}}, s2_sum_reg.mid_carry};
        priority if (trivial_reg)
        begin
            keep       = 1'b1;
            value_next = '0;
        end
        else if (narrow_reg)
        begin
            // narrow product is below 2^64, split at bit 32
            keep       = (s2_sum_reg.lo[HALF_W-1:0] >= thr_reg[HALF_W-1:0]);
            value_next = {{HALF_W{1'b0}}, s2_sum_reg.lo[WORD_W-1:HALF_W]};
        end
        else
        begin
            keep       = (s2_sum_reg.lo >= thr_reg);
            value_next = hi_sum;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg  <= 1'b0;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s0_valid_reg  <= in_valid && in_ready;
            s1_valid_reg  <= s0_valid_reg;
            s2_valid_reg  <= s1_valid_reg;
            out_valid_reg <= s2_valid_reg && keep;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s0_word_reg <= rand_word;
            s1_pp_reg   <= s1_pp_next;
            s2_sum_reg  <= s2_sum_next;
            value_reg   <= value_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign value     = value_reg;

    // ------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------
    a_no_accept_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> !in_ready)
        else $error("word taken while threshold still being computed");

    a_busy_from_write: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy_reg) |-> $past(cfg_wr))
        else $error("remainder unit started without a range write");

    a_thr_below_range: assert property (@(posedge clk) disable iff (!rst_n)
        (!busy_reg && !trivial_reg) |-> (thr_reg < range_reg))
        else $error("reject threshold not below range");

    a_trivial_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && trivial_reg && !busy_reg && $stable(range_reg)
            && $past(adv)) |-> (value_reg == '0))
        else $error("nonzero word for range 0 or 1");

endmodule
